### rtl/tavs_pkg.sv
// ============================================================================
// tavs_pkg : shared types, constants and functions
// Types and helpers for the autotile role classifier and variant selector.
// ============================================================================
`default_nettype none

package tavs_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_HASH_SEED   = 2'd0;
    localparam logic [1:0] REG_BASE_COUNT  = 2'd1;
    localparam logic [1:0] REG_DECOR_COUNT = 2'd2;

    // Role codes
    localparam logic [3:0] ROLE_INTERIOR = 4'd0;
    localparam logic [3:0] ROLE_TOP      = 4'd1;
    localparam logic [3:0] ROLE_BOTTOM   = 4'd2;
    localparam logic [3:0] ROLE_LEFT     = 4'd3;
    localparam logic [3:0] ROLE_RIGHT    = 4'd4;
    localparam logic [3:0] ROLE_TL       = 4'd5;
    localparam logic [3:0] ROLE_TR       = 4'd6;
    localparam logic [3:0] ROLE_BL       = 4'd7;
    localparam logic [3:0] ROLE_BR       = 4'd8;
    localparam logic [3:0] ROLE_OUT_TL   = 4'd9;
    localparam logic [3:0] ROLE_OUT_TR   = 4'd10;
    localparam logic [3:0] ROLE_OUT_BL   = 4'd11;
    localparam logic [3:0] ROLE_OUT_BR   = 4'd12;

    // Hash constants
    localparam logic [31:0] MUL_X     = 32'd73856093;
    localparam logic [31:0] MUL_Y     = 32'd19349663;
    localparam logic [31:0] MUL_S     = 32'd83492791;
    localparam logic [31:0] MUL_MIX   = 32'd1274126177;
    localparam logic [31:0] SALT_BASE  = 32'hA5F1_3C9D;
    localparam logic [31:0] SALT_ROLL  = 32'h5C2D_91EB;
    localparam logic [31:0] SALT_DECOR = 32'hC97F_4A1D;
    // Decor roll is 1 in 8: low bits of the roll hash all zero
    localparam int unsigned DECOR_BITS = 3;

    // Remainder pipeline geometry
    localparam int unsigned DVD_W      = 32;
    localparam int unsigned DSR_W      = 8;
    localparam int unsigned DIV_BPS    = 4;
    localparam int unsigned DIV_STAGES = DVD_W / DIV_BPS;

    typedef struct packed {
        logic signed [31:0] tile_x;
        logic signed [31:0] tile_y;
        logic [1:0]         surface_type;
        logic [7:0]         neighbor_mask;
    } tile_t;

    typedef struct packed {
        logic [3:0] role;
        logic       use_decor;
        logic [7:0] variant_index;
    } result_t;

    // Side info carried alongside the remainder pipeline
    typedef struct packed {
        logic [3:0] role;
        logic       use_decor;
        logic       force_zero;
    } side_t;

    // Ordered role rules on the neighbor mask (N, NE, E, SE, S, SW, W, NW)
    function automatic logic [3:0] classify(input logic [7:0] m);
        logic n, ne, e, se, s, sw, w, nw;
        logic [3:0] r;
        n  = m[0]; ne = m[1]; e = m[2]; se = m[3];
        s  = m[4]; sw = m[5]; w = m[6]; nw = m[7];
        if (n && e && s && w) begin
            if (!nw)      r = ROLE_OUT_TL;
            else if (!ne) r = ROLE_OUT_TR;
            else if (!sw) r = ROLE_OUT_BL;
            else if (!se) r = ROLE_OUT_BR;
            else          r = ROLE_INTERIOR;
        end
        else if (!n && e && s && w)                    r = ROLE_TOP;
        else if (!s && n && e && w)                    r = ROLE_BOTTOM;
        else if (!w && n && e && s)                    r = ROLE_LEFT;
        else if (!e && n && s && w)                    r = ROLE_RIGHT;
        else if (!n && !w && e && s)                   r = ROLE_TL;
        else if (!n && !e && w && s)                   r = ROLE_TR;
        else if (!s && !w && n && e)                   r = ROLE_BL;
        else if (!s && !e && n && w)                   r = ROLE_BR;
        else if (!n && !e && !s && sw && w && nw)      r = ROLE_RIGHT;
        else if (!n && ne && e && se && !s && !w)      r = ROLE_LEFT;
        else if (!n && !e && se && s && sw && !w)      r = ROLE_TOP;
        else if (n && ne && !e && !s && !w && nw)      r = ROLE_BOTTOM;
        else                                           r = ROLE_INTERIOR;
        return r;
    endfunction

    // Front half of the mix, up to the multiply operand
    function automatic logic [31:0] mix_front(input logic [31:0] seed_salt,
                                              input logic [31:0] px,
                                              input logic [31:0] py,
                                              input logic [31:0] ps);
        logic [31:0] v;
        v = seed_salt ^ px ^ py ^ ps;
        return v ^ (v >> 13);
    endfunction

    // Back half of the mix, after the multiply
    function automatic logic [31:0] mix_back(input logic [31:0] p);
        return p ^ (p >> 16);
    endfunction

    // One restoring remainder step: shift in one dividend bit
    function automatic logic [DSR_W-1:0] rem_step(input logic [DSR_W-1:0] r,
                                                   input logic             b,
                                                   input logic [DSR_W-1:0] d);
        logic [DSR_W:0] t;
        t = {r, b};
        if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
        end
        return t[DSR_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/tavs_rem_pipe.sv
// ============================================================================
// tavs_rem_pipe : pipelined remainder unit
// 32-bit by 8-bit restoring remainder, four dividend bits per stage.
// ============================================================================
`default_nettype none

module tavs_rem_pipe (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [tavs_pkg::DVD_W-1:0]  dividend,
    input  wire logic [tavs_pkg::DSR_W-1:0]  divisor,
    input  wire tavs_pkg::side_t             side_in,
    output logic                             out_valid,
    output logic [tavs_pkg::DSR_W-1:0]       remainder,
    output tavs_pkg::side_t                  side_out
);
    import tavs_pkg::*;

    logic             vld_reg  [DIV_STAGES];
    logic [DVD_W-1:0] dvd_reg  [DIV_STAGES];
    logic [DSR_W-1:0] rem_reg  [DIV_STAGES];
    logic [DSR_W-1:0] dsr_reg  [DIV_STAGES];
    side_t            side_reg [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic             src_vld;
        logic [DVD_W-1:0] src_dvd;
        logic [DSR_W-1:0] src_rem;
        logic [DSR_W-1:0] src_dsr;
        side_t            src_side;
        logic [DSR_W-1:0] rem_next;
        logic [DVD_W-1:0] dvd_next;

        // Stage source: module inputs for the first stage, previous stage otherwise
        if (g == 0) begin : g_first
            always_comb
            begin
                src_vld  = in_valid;
                src_dvd  = dividend;
                src_rem  = '0;
                src_dsr  = divisor;
                src_side = side_in;
            end
        end
        else begin : g_rest
            always_comb
            begin
                src_vld  = vld_reg[g-1];
                src_dvd  = dvd_reg[g-1];
                src_rem  = rem_reg[g-1];
                src_dsr  = dsr_reg[g-1];
                src_side = side_reg[g-1];
            end
        end

        // Four remainder steps, top dividend bits first
        always_comb
        begin
            rem_next = src_rem;
            for (int k = 0; k < DIV_BPS; k++) begin
                rem_next = rem_step(rem_next, src_dvd[DVD_W-1-k], src_dsr);
            end
            dvd_next = src_dvd << DIV_BPS;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                vld_reg[g] <= 1'b0;
            end
            else begin
                vld_reg[g] <= src_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            dvd_reg[g]  <= dvd_next;
            rem_reg[g]  <= rem_next;
            dsr_reg[g]  <= src_dsr;
            side_reg[g] <= src_side;
        end
    end

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign remainder = rem_reg[DIV_STAGES-1];
    assign side_out  = side_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

### rtl/tile_autotile_role_and_variant_select.sv
// ============================================================================
// tile_autotile_role_and_variant_select : autotile role and variant pipeline
// Classifies a tile's neighbor mask and picks a hashed interior variant.
// ============================================================================
// Usage:
//   Input: drive item and pulse start; a transfer happens on every edge with
//   start high, since busy is held low. A new tile may enter every cycle.
//   Configuration: cfg_we with cfg_addr / cfg_wdata writes hash seed (0),
//   base variant count (1) or decor variant count (2); other indexes are
//   ignored. Write only while no tile is in flight.
//   Output: result is valid for one cycle with done high. There is no
//   backpressure; the receiver must take it.
//   Throughput is one tile per cycle. The pipeline holds three hash stages
//   (coordinate multiplies, mix multiply, mix finish and select), eight
//   stages of the 4-bit-per-stage remainder unit and one output register.
//   Reset clears valid bits and config registers (all zero); tiles in flight
//   are dropped.
// ============================================================================
`default_nettype none

module tile_autotile_role_and_variant_select (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire tavs_pkg::tile_t   item,
    output logic                   done,
    output tavs_pkg::result_t      result,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_addr,
    input  wire logic [31:0]       cfg_wdata
);
    import tavs_pkg::*;

    // Configuration registers
    logic [31:0] hash_seed_reg;
    logic [7:0]  base_count_reg;
    logic [7:0]  decor_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hash_seed_reg   <= '0;
            base_count_reg  <= '0;
            decor_count_reg <= '0;
        end
        else if (cfg_we) begin
            unique case (cfg_addr)
                REG_HASH_SEED:   hash_seed_reg   <= cfg_wdata;
                REG_BASE_COUNT:  base_count_reg  <= cfg_wdata[7:0];
                REG_DECOR_COUNT: decor_count_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Fully pipelined: never back-pressures
    assign busy = 1'b0;

    // Stage 1: coordinate products and role
    logic        s1_vld_reg;
    logic [31:0] s1_px_reg, s1_py_reg, s1_ps_reg;
    logic [3:0]  s1_role_reg;
    logic [31:0] x_u, y_u;

    assign x_u = item.tile_x;
    assign y_u = item.tile_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_vld_reg <= 1'b0;
        end
        else begin
            s1_vld_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_px_reg   <= x_u * MUL_X;
        s1_py_reg   <= y_u * MUL_Y;
        s1_ps_reg   <= {30'd0, item.surface_type} * MUL_S;
        s1_role_reg <= classify(item.neighbor_mask);
    end

    // Stage 2: three salted mixes through the multiply
    logic        s2_vld_reg;
    logic [31:0] s2_mb_reg, s2_mr_reg, s2_md_reg;
    logic [3:0]  s2_role_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s2_vld_reg <= 1'b0;
        end
        else begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_mb_reg   <= mix_front(hash_seed_reg ^ SALT_BASE, s1_px_reg, s1_py_reg,
                                 s1_ps_reg) * MUL_MIX;
        s2_mr_reg   <= mix_front(hash_seed_reg ^ SALT_ROLL, s1_px_reg, s1_py_reg,
                                 s1_ps_reg) * MUL_MIX;
        s2_md_reg   <= mix_front(hash_seed_reg ^ SALT_DECOR, s1_px_reg, s1_py_reg,
                                 s1_ps_reg) * MUL_MIX;
        s2_role_reg <= s1_role_reg;
    end

    // Stage 3: finish the mixes, decor roll, pick dividend and divisor
    logic        s3_vld_reg;
    logic [31:0] s3_dvd_reg;
    logic [7:0]  s3_dsr_reg;
    side_t       s3_side_reg;
    logic [31:0] h_base, h_roll, h_decor;
    logic        interior, decor_next;
    side_t       s3_side_next;

    always_comb
    begin
        h_base   = mix_back(s2_mb_reg);
        h_roll   = mix_back(s2_mr_reg);
        h_decor  = mix_back(s2_md_reg);
        interior = (s2_role_reg == ROLE_INTERIOR);
        decor_next = interior && (base_count_reg != '0) && (decor_count_reg != '0)
                     && (h_roll[DECOR_BITS-1:0] == '0);
        s3_side_next.role       = s2_role_reg;
        s3_side_next.use_decor  = decor_next;
        s3_side_next.force_zero = !interior || (base_count_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s3_vld_reg <= 1'b0;
        end
        else begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_dvd_reg  <= decor_next ? h_decor : h_base;
        s3_dsr_reg  <= decor_next ? decor_count_reg : base_count_reg;
        s3_side_reg <= s3_side_next;
    end

    // Remainder unit
    logic       rem_vld;
    logic [7:0] rem_val;
    side_t      rem_side;

    tavs_rem_pipe u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_vld_reg),
        .dividend  (s3_dvd_reg),
        .divisor   (s3_dsr_reg),
        .side_in   (s3_side_reg),
        .out_valid (rem_vld),
        .remainder (rem_val),
        .side_out  (rem_side)
    );

    // Output register
    logic    done_reg;
    result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= rem_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.role          <= rem_side.role;
        result_reg.use_decor     <= rem_side.use_decor;
        result_reg.variant_index <= rem_side.force_zero ? 8'd0 : rem_val;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire
